/* hdl/bounding_sphere_fit_core_assert.svh */
// Assertion macros used by the bounding sphere fit controller
`ifndef BOUNDING_SPHERE_FIT_CORE_ASSERT_SVH
`define BOUNDING_SPHERE_FIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define BSF_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define BSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bsf_pkg.sv */
// Shared constants, command and status types for the bounding sphere fit core
`default_nettype none

package bsf_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W = 32;
  localparam int VTX_W   = 3 * COORD_W;
  localparam int ROOT_W  = COORD_W + 1;
  localparam int DIST_W  = 2 * ROOT_W;
  localparam int NUM_W   = COORD_W + ROOT_W;
  localparam int RAD_W   = 31;

  localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_PT
  } rd_sel_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_RR,
    MUL_SCALE
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic             load_en;
    logic             rd_en;
    rd_sel_e          rd_sel;
    logic [1:0]       axis;
    logic [IDX_W-1:0] pt_idx;
    logic             lo_load;
    logic             seed_mode;
    mul_op_e          mul_op;
    acc_op_e          acc_op;
    logic             sqrt_start;
    logic             seed_pick;
    logic             first_axis;
    logic             d_load;
    logic             delta_load;
    logic             div_start;
    logic             c_update;
    logic             r_grow;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             outside;
    logic             sqrt_busy;
    logic             div_busy;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/bsf_sqrt.sv */
// Iterative integer square root, one root bit per cycle
`default_nettype none

module bsf_sqrt import bsf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIST_W-1:0] rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o,
  output logic              rem_nz_o
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_SW = $clog2(ROOT_W + 1);

  logic [DIST_W-1:0] rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_SW-1:0] cnt_q;
  logic              busy_q;

  logic [REM_W+1:0]  trial_rem;
  logic [REM_W+1:0]  trial_sub;
  logic              take;

  assign trial_rem = {rem_q, rad_q[DIST_W-1 -: 2]};
  assign trial_sub = {2'b00, root_q, 2'b01};
  assign take      = trial_rem >= trial_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_SW'(ROOT_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CNT_SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (take) begin
        rem_q  <= REM_W'(trial_rem - trial_sub);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= REM_W'(trial_rem);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o   = busy_q;
  assign root_o   = root_q;
  assign rem_nz_o = rem_q != '0;

endmodule

`default_nettype wire

/* hdl/bsf_div.sv */
// Iterative restoring divider, one quotient bit per cycle
`default_nettype none

module bsf_div import bsf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [ROOT_W-1:0]  den_i,
  output logic               busy_o,
  output logic [COORD_W-1:0] quot_o
);

  localparam int CNT_DW = $clog2(COORD_W + 1);

  logic [ROOT_W-1:0]  rem_q;
  logic [ROOT_W-1:0]  den_q;
  logic [COORD_W-1:0] low_q;
  logic [COORD_W-1:0] quot_q;
  logic [CNT_DW-1:0]  cnt_q;
  logic               busy_q;

  logic [ROOT_W:0]    trial;
  logic               take;

  assign trial = {rem_q, low_q[COORD_W-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_DW'(COORD_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CNT_DW'(1);
    end
  end

  // high part of the dividend is below the divisor, so the quotient fits COORD_W bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[NUM_W-1:COORD_W];
      low_q  <= num_i[COORD_W-1:0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      low_q <= low_q << 1;
      if (take) begin
        rem_q  <= ROOT_W'(trial - {1'b0, den_q});
        quot_q <= {quot_q[COORD_W-2:0], 1'b1};
      end else begin
        rem_q  <= ROOT_W'(trial);
        quot_q <= {quot_q[COORD_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* hdl/bsf_dp.sv */
// Datapath: vertex store, extreme tracking, sphere registers and arithmetic units
`default_nettype none

module bsf_dp import bsf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [COORD_W-1:0] center_x_o,
  output logic signed [COORD_W-1:0] center_y_o,
  output logic signed [COORD_W-1:0] center_z_o,
  output logic [RAD_W-1:0]          radius_o,
  output logic                      dropped_vertices_o
);

  logic [VTX_W-1:0] mem_q [MAX_POINTS];

  logic signed [COORD_W-1:0] vin   [3];
  logic signed [COORD_W-1:0] rd_q  [3];
  logic signed [COORD_W-1:0] lo_q  [3];
  logic signed [COORD_W-1:0] c_q   [3];
  logic signed [COORD_W-1:0] min_q [3];
  logic signed [COORD_W-1:0] max_q [3];
  logic [IDX_W-1:0]          ext_q [6];

  logic [CNT_W-1:0]  count_q;
  logic              ovf_q;
  logic [ROOT_W-1:0] r_q;
  logic [ROOT_W-1:0] d_q;
  logic [ROOT_W-1:0] delta_q;
  logic [DIST_W-1:0] acc_q;
  logic [DIST_W-1:0] prod_q;

  logic signed [COORD_W-1:0] base  [3];
  logic signed [COORD_W:0]   diff  [3];
  logic signed [COORD_W:0]   ndiff [3];
  logic [COORD_W-1:0]        dmag  [3];
  logic signed [COORD_W:0]   msum  [3];

  logic                      out_valid_q;
  logic signed [COORD_W-1:0] res_c_q [3];
  logic [RAD_W-1:0]          res_r_q;
  logic                      res_drop_q;

  logic              store_ok;
  logic [IDX_W-1:0]  rd_addr;
  logic [ROOT_W-1:0] mul_a;
  logic [ROOT_W-1:0] mul_b;
  logic [DIST_W-1:0] prod_d;
  logic              sqrt_busy;
  logic [ROOT_W-1:0] sqrt_root;
  logic              sqrt_rem_nz;
  logic              div_busy;
  logic [COORD_W-1:0] quot;
  logic [ROOT_W-1:0] cand;
  logic [ROOT_W:0]   delta_sum;

  assign vin[0] = pos_x_i;
  assign vin[1] = pos_y_i;
  assign vin[2] = pos_z_i;

  assign store_ok = count_q < CNT_W'(MAX_POINTS);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_LO:   rd_addr = ext_q[{cmd_i.axis, 1'b0}];
      RD_HI:   rd_addr = ext_q[{cmd_i.axis, 1'b1}];
      RD_PT:   rd_addr = cmd_i.pt_idx;
      default: rd_addr = cmd_i.pt_idx;
    endcase
  end

  // per-axis offset of the fetched vertex from the seed end or the centre
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      base[k]  = cmd_i.seed_mode ? lo_q[k] : c_q[k];
      diff[k]  = {rd_q[k][COORD_W-1], rd_q[k]} - {base[k][COORD_W-1], base[k]};
      ndiff[k] = -diff[k];
      dmag[k]  = diff[k][COORD_W] ? ndiff[k][COORD_W-1:0] : diff[k][COORD_W-1:0];
      msum[k]  = {lo_q[k][COORD_W-1], lo_q[k]} + {rd_q[k][COORD_W-1], rd_q[k]};
    end
  end

  always_comb begin
    case (cmd_i.mul_op)
      MUL_SQ: begin
        mul_a = {1'b0, dmag[cmd_i.axis]};
        mul_b = {1'b0, dmag[cmd_i.axis]};
      end
      MUL_RR: begin
        mul_a = r_q;
        mul_b = r_q;
      end
      MUL_SCALE: begin
        mul_a = {1'b0, dmag[cmd_i.axis]};
        mul_b = delta_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d    = DIST_W'(mul_a) * DIST_W'(mul_b);
  assign cand      = {1'b0, sqrt_root[ROOT_W-1:1]};
  assign delta_sum = {1'b0, d_q} - {1'b0, r_q} + (ROOT_W+1)'(1);

  bsf_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.sqrt_start),
    .rad_i    (acc_q),
    .busy_o   (sqrt_busy),
    .root_o   (sqrt_root),
    .rem_nz_o (sqrt_rem_nz)
  );

  bsf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q[NUM_W-1:0]),
    .den_i   (d_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && store_ok) begin
      mem_q[count_q[IDX_W-1:0]] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    if (cmd_i.rd_en) begin
      for (int k = 0; k < 3; k++) begin
        rd_q[k] <= mem_q[rd_addr][k*COORD_W +: COORD_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lo_load) begin
      lo_q <= rd_q;
    end
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= prod_d;
    end
    case (cmd_i.acc_op)
      ACC_CLR:  acc_q <= '0;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      ACC_HOLD: acc_q <= acc_q;
      default:  acc_q <= acc_q;
    endcase
    // the x pair always seeds; y and z replace it only when strictly wider
    if (cmd_i.seed_pick && (cmd_i.first_axis || cand > r_q)) begin
      r_q <= cand;
      for (int k = 0; k < 3; k++) begin
        c_q[k] <= msum[k][COORD_W:1];
      end
    end
    if (cmd_i.d_load) begin
      d_q <= sqrt_root + ROOT_W'(sqrt_rem_nz);
    end
    if (cmd_i.delta_load) begin
      delta_q <= delta_sum[ROOT_W:1];
    end
    if (cmd_i.c_update) begin
      if (diff[cmd_i.axis][COORD_W]) begin
        c_q[cmd_i.axis] <= c_q[cmd_i.axis] - quot;
      end else begin
        c_q[cmd_i.axis] <= c_q[cmd_i.axis] + quot;
      end
    end
    if (cmd_i.r_grow) begin
      r_q <= r_q + delta_q;
    end
    if (cmd_i.out_load) begin
      res_c_q    <= c_q;
      res_r_q    <= (r_q > ROOT_W'(RADIUS_MAX)) ? RADIUS_MAX : r_q[RAD_W-1:0];
      res_drop_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
      end
      for (int j = 0; j < 6; j++) begin
        ext_q[j] <= '0;
      end
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        // start a fresh cloud
        count_q <= '0;
        ovf_q   <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          min_q[k] <= '0;
          max_q[k] <= '0;
        end
        for (int j = 0; j < 6; j++) begin
          ext_q[j] <= '0;
        end
      end else if (cmd_i.load_en) begin
        if (store_ok) begin
          count_q <= count_q + 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (count_q == '0 || vin[k] < min_q[k]) begin
              min_q[k]     <= vin[k];
              ext_q[2 * k] <= count_q[IDX_W-1:0];
            end
            if (count_q == '0 || vin[k] > max_q[k]) begin
              max_q[k]         <= vin[k];
              ext_q[2 * k + 1] <= count_q[IDX_W-1:0];
            end
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.count     = count_q;
  assign sts_o.outside   = acc_q > prod_q;
  assign sts_o.sqrt_busy = sqrt_busy;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o        = out_valid_q;
  assign center_x_o         = res_c_q[0];
  assign center_y_o         = res_c_q[1];
  assign center_z_o         = res_c_q[2];
  assign radius_o           = res_r_q;
  assign dropped_vertices_o = res_drop_q;

endmodule

`default_nettype wire

/* hdl/bsf_ctrl.sv */
// Controller: sequences loading, sphere seeding and the growth pass
`default_nettype none

`include "bounding_sphere_fit_core_assert.svh"

module bsf_ctrl import bsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_vertex_i,
  output logic in_stall_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_SQ,
    ST_CMP,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_PICK,
    ST_G_RD,
    ST_GROW_D,
    ST_GROW_DELTA,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RGROW,
    ST_NEXT,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [1:0]       axis_q;
  logic [1:0]       k_q;
  logic [IDX_W-1:0] pt_q;
  logic             seed_q;
  logic             last_pt;

  assign last_pt    = (CNT_W'(pt_q) + CNT_W'(1)) == sts_i.count;
  assign in_stall_o = state_q != ST_IDLE;

  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_PT;
    cmd_o.mul_op     = MUL_NONE;
    cmd_o.acc_op     = ACC_HOLD;
    cmd_o.axis       = k_q;
    cmd_o.pt_idx     = pt_q;
    cmd_o.seed_mode  = seed_q;
    cmd_o.first_axis = axis_q == 2'd0;
    case (state_q)
      ST_IDLE:  cmd_o.load_en = in_valid_i;
      ST_RD_LO: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LO;
        cmd_o.axis   = axis_q;
      end
      ST_RD_HI: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_HI;
        cmd_o.axis    = axis_q;
        cmd_o.lo_load = 1'b1;
      end
      ST_SQ: begin
        // squares are registered in prod_q and enter the sum in the next cycle; r*r rides the last slot
        cmd_o.mul_op = (k_q == 2'd3) ? MUL_RR : MUL_SQ;
        cmd_o.acc_op = (k_q == 2'd0) ? ACC_CLR : ACC_ADD;
      end
      ST_SQRT_GO:    cmd_o.sqrt_start = 1'b1;
      ST_PICK:       cmd_o.seed_pick = 1'b1;
      ST_G_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PT;
      end
      ST_GROW_D:     cmd_o.d_load = 1'b1;
      ST_GROW_DELTA: cmd_o.delta_load = 1'b1;
      ST_SCALE:      cmd_o.mul_op = MUL_SCALE;
      ST_DIV_GO:     cmd_o.div_start = 1'b1;
      ST_DIV_WAIT:   cmd_o.c_update = !sts_i.div_busy;
      ST_RGROW:      cmd_o.r_grow = 1'b1;
      ST_FINISH:     cmd_o.out_load = sts_i.out_free;
      default:       cmd_o.load_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
      k_q     <= '0;
      pt_q    <= '0;
      seed_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && last_vertex_i) begin
            axis_q  <= '0;
            k_q     <= '0;
            seed_q  <= 1'b1;
            state_q <= ST_RD_LO;
          end
        end
        ST_RD_LO: state_q <= ST_RD_HI;
        ST_RD_HI: state_q <= ST_SQ;
        ST_SQ: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_q <= seed_q ? ST_SQRT_GO : ST_CMP;
          end
        end
        ST_CMP:     state_q <= sts_i.outside ? ST_SQRT_GO : ST_NEXT;
        ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (!sts_i.sqrt_busy) begin
            state_q <= seed_q ? ST_PICK : ST_GROW_D;
          end
        end
        ST_PICK: begin
          if (axis_q == 2'd2) begin
            seed_q  <= 1'b0;
            pt_q    <= '0;
            state_q <= ST_G_RD;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_RD_LO;
          end
        end
        ST_G_RD:       state_q <= ST_SQ;
        ST_GROW_D:     state_q <= ST_GROW_DELTA;
        ST_GROW_DELTA: state_q <= ST_SCALE;
        ST_SCALE:      state_q <= ST_DIV_GO;
        ST_DIV_GO:     state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (!sts_i.div_busy) begin
            if (k_q == 2'd2) begin
              k_q     <= '0;
              state_q <= ST_RGROW;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_SCALE;
            end
          end
        end
        ST_RGROW: state_q <= ST_NEXT;
        ST_NEXT: begin
          if (last_pt) begin
            state_q <= ST_FINISH;
          end else begin
            pt_q    <= pt_q + 1'b1;
            state_q <= ST_G_RD;
          end
        end
        ST_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `BSF_ASSERT_NEXT(a_last_starts_seed, state_q == ST_IDLE && in_valid_i && last_vertex_i, state_q == ST_RD_LO, "last item did not start seeding")
  `BSF_ASSERT_HOLDS(a_units_idle, state_q == ST_IDLE, !sts_i.sqrt_busy && !sts_i.div_busy, "arithmetic unit busy while idle")
  `BSF_ASSERT_HOLDS(a_pt_in_range, state_q == ST_G_RD, CNT_W'(pt_q) < sts_i.count, "growth pass reads past stored vertices")
  `BSF_ASSERT_HOLDS(a_seed_axis_range, seed_q && state_q != ST_IDLE, axis_q != 2'd3, "seed axis out of range")

endmodule

`default_nettype wire

/* hdl/bounding_sphere_fit_core.sv */
// Top level of the bounding sphere fit core: controller plus datapath
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  vertex  | in        | in_valid_i / in_stall_o   | pos_x_i, pos_y_i, pos_z_i, last_vertex_i
//  sphere  | out       | out_valid_o / out_stall_i | center_x_o, center_y_o, center_z_o,
//          |           |                           | radius_o, dropped_vertices_o
//
// While the core is idle, vertices load at one item per cycle into a 1024-entry store
// with one read port. A last item starts the fit: the core seeds the sphere from the
// three extreme pairs, then checks each stored vertex against it; a vertex outside grows
// it by a bit-serial square root and three bit-serial divides per growth step.
// in_stall_o is high from the last item until the result enters the output register,
// which may hold a result while the next cloud loads. Reset clears all cloud state.
`default_nettype none

module bounding_sphere_fit_core import bsf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  input  logic                      last_vertex_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] center_x_o,
  output logic signed [COORD_W-1:0] center_y_o,
  output logic signed [COORD_W-1:0] center_z_o,
  output logic [RAD_W-1:0]          radius_o,
  output logic                      dropped_vertices_o
);

  cmd_t cmd;
  sts_t sts;

  bsf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_vertex_i (last_vertex_i),
    .in_stall_o    (in_stall_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  bsf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .center_x_o         (center_x_o),
    .center_y_o         (center_y_o),
    .center_z_o         (center_z_o),
    .radius_o           (radius_o),
    .dropped_vertices_o (dropped_vertices_o)
  );

endmodule

`default_nettype wire
